### hdl/rcns_pkg.sv
// Shared types, constants and register codes for the RGBC clear-normalising
// serpentine scan block. No dependencies; every other file in hdl imports it.
package rcns_pkg;

	// Scan geometry limits.
	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 128;

	// Field widths.
	localparam int CNT_W   = 16;
	localparam int GAIN_W  = 10;
	localparam int DIM_W   = 8;
	localparam int ROW_W   = 7;
	localparam int COL_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 3;

	// Divider widths: the product colour * gain, and the partial remainder.
	localparam int PROD_W  = CNT_W + GAIN_W;
	localparam int REM_W   = PROD_W;
	localparam int SHIFT_W = 4;
	localparam logic [SHIFT_W-1:0] SHIFT_TOP = SHIFT_W'(BYTE_W);

	localparam int NUM_CH = 3;
	localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

	// Register reset values.
	localparam logic [DIM_W-1:0]  RST_NUM_COLUMNS = 8'd84;
	localparam logic [DIM_W-1:0]  RST_NUM_ROWS    = 8'd128;
	localparam logic [GAIN_W-1:0] RST_GAIN_RED    = 10'd261;
	localparam logic [GAIN_W-1:0] RST_GAIN_GREEN  = 10'd338;
	localparam logic [GAIN_W-1:0] RST_GAIN_BLUE   = 10'd364;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_COLUMNS = 3'd0,
		REG_NUM_ROWS    = 3'd1,
		REG_GAIN_RED    = 3'd2,
		REG_GAIN_GREEN  = 3'd3,
		REG_GAIN_BLUE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]  num_columns;
		logic [DIM_W-1:0]  num_rows;
		logic [GAIN_W-1:0] gain_red;
		logic [GAIN_W-1:0] gain_green;
		logic [GAIN_W-1:0] gain_blue;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] clear_count;
		logic [CNT_W-1:0] red_count;
		logic [CNT_W-1:0] green_count;
		logic [CNT_W-1:0] blue_count;
	} reading_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              scan_last;
	} pixel_t;

	// Storage position of one scan point.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             scan_last;
	} pos_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_MUL,
		N_SCALE,
		N_DIV,
		N_DONE
	} norm_state_t;

endpackage

### hdl/rcns_regs.sv
// Configuration registers: scan dimensions and the three colour gains.
// Depends on rcns_pkg.
module rcns_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcns_pkg::CFG_W-1:0]     cfg_wdata,
	output rcns_pkg::cfg_t                 cfg
);
	import rcns_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_columns <= RST_NUM_COLUMNS;
			cfg_q.num_rows    <= RST_NUM_ROWS;
			cfg_q.gain_red    <= RST_GAIN_RED;
			cfg_q.gain_green  <= RST_GAIN_GREEN;
			cfg_q.gain_blue   <= RST_GAIN_BLUE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_COLUMNS: cfg_q.num_columns <= cfg_wdata[DIM_W-1:0];
				REG_NUM_ROWS:    cfg_q.num_rows    <= cfg_wdata[DIM_W-1:0];
				REG_GAIN_RED:    cfg_q.gain_red    <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_GREEN:  cfg_q.gain_green  <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_BLUE:   cfg_q.gain_blue   <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/rcns_raster.sv
// Serpentine raster counters and the storage position of the current point.
// Depends on rcns_pkg.
module rcns_raster (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  rcns_pkg::cfg_t cfg,
	output rcns_pkg::pos_t pos
);
	import rcns_pkg::*;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] ncols, nrows, col_ext, row_ext, col_c, col_mir;
	logic             row_end, scan_end;

	always_comb begin
		// A dimension of zero acts as one; anything above the limit is clamped.
		if (cfg.num_columns == '0)
			ncols = DIM_W'(1);
		else if (cfg.num_columns > DIM_W'(MAX_COLS))
			ncols = DIM_W'(MAX_COLS);
		else
			ncols = cfg.num_columns;
		if (cfg.num_rows == '0)
			nrows = DIM_W'(1);
		else if (cfg.num_rows > DIM_W'(MAX_ROWS))
			nrows = DIM_W'(MAX_ROWS);
		else
			nrows = cfg.num_rows;

		col_ext  = DIM_W'(col_q);
		row_ext  = DIM_W'(row_q);
		row_end  = (col_ext + DIM_W'(1)) >= ncols;
		scan_end = row_end && ((row_ext + DIM_W'(1)) >= nrows);
		// A counter left beyond the row by a mid-scan change mirrors as the last column.
		col_c    = (col_ext < ncols) ? col_ext : ncols - DIM_W'(1);
		col_mir  = ncols - DIM_W'(1) - col_c;

		pos.row       = row_q;
		pos.column    = row_q[0] ? col_q : col_mir[COL_W-1:0];
		pos.scan_last = scan_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= scan_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

### hdl/rcns_norm.sv
// Colour normaliser: one multiplier and one compare-subtract unit, shared by
// the three channels under a small sequencer. Depends on rcns_pkg.
module rcns_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcns_pkg::reading_t reading,
	input  rcns_pkg::cfg_t     cfg,
	input  logic               take,
	output logic               ready,
	output logic               done,
	output rcns_pkg::rgb_t     rgb
);
	import rcns_pkg::*;

	norm_state_t state_q, state_d;

	logic [1:0]          ch_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [CNT_W-1:0]    den_q;
	logic [CNT_W-1:0]    color_q [NUM_CH];
	logic [PROD_W-1:0]   prod_q;
	logic [REM_W-1:0]    rem_q;
	logic [BYTE_W-1:0]   quo_q;
	logic [BYTE_W-1:0]   res_q [NUM_CH];

	logic [CNT_W-1:0]    color_sel;
	logic [GAIN_W-1:0]   gain_sel;
	logic [PROD_W-1:0]   mul;
	logic [PROD_W+BYTE_W-1:0] scaled;
	logic [REM_W-1:0]    dsh, diff;
	logic                ge, ch_done;
	logic [BYTE_W-1:0]   quo_next, ch_res;

	always_comb begin
		case (ch_q)
			2'd0:    begin color_sel = color_q[0]; gain_sel = cfg.gain_red;   end
			2'd1:    begin color_sel = color_q[1]; gain_sel = cfg.gain_green; end
			default: begin color_sel = color_q[2]; gain_sel = cfg.gain_blue;  end
		endcase
		mul = PROD_W'(color_sel) * PROD_W'(gain_sel);

		// x * 255 as (x << 8) - x; the low byte drops because the divisor is clear * 256.
		scaled = {prod_q, {BYTE_W{1'b0}}} - (PROD_W+BYTE_W)'(prod_q);

		dsh  = REM_W'(den_q) << shift_q;
		ge   = rem_q >= dsh;
		diff = rem_q - dsh;

		quo_next = quo_q;
		if (ge)
			quo_next[shift_q[2:0]] = 1'b1;

		ch_done = 1'b0;
		ch_res  = quo_next;
		if (shift_q == SHIFT_TOP) begin
			// Top step only tests for overflow: zero clear gives black, overflow saturates.
			if (den_q == '0) begin
				ch_done = 1'b1;
				ch_res  = '0;
			end else if (ge) begin
				ch_done = 1'b1;
				ch_res  = '1;
			end
		end else if (shift_q == '0) begin
			ch_done = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE:  if (start) state_d = N_MUL;
			N_MUL:   state_d = N_SCALE;
			N_SCALE: state_d = N_DIV;
			N_DIV: begin
				if (ch_done)
					state_d = (ch_q == CH_LAST) ? N_DONE : N_MUL;
			end
			N_DONE:  if (take) state_d = N_IDLE;
			default: state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= N_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ch_q <= '0;
		else if (state_q == N_IDLE && start)
			ch_q <= '0;
		else if (state_q == N_DIV && ch_done && ch_q != CH_LAST)
			ch_q <= ch_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					den_q      <= reading.clear_count;
					color_q[0] <= reading.red_count;
					color_q[1] <= reading.green_count;
					color_q[2] <= reading.blue_count;
				end
			end
			N_MUL: prod_q <= mul;
			N_SCALE: begin
				rem_q   <= scaled[PROD_W+BYTE_W-1:BYTE_W];
				shift_q <= SHIFT_TOP;
				quo_q   <= '0;
			end
			N_DIV: begin
				if (shift_q != SHIFT_TOP && ge)
					rem_q <= diff;
				quo_q   <= quo_next;
				shift_q <= shift_q - SHIFT_W'(1);
				if (ch_done)
					res_q[ch_q] <= ch_res;
			end
			default: ;
		endcase
	end

	assign ready     = (state_q == N_IDLE);
	assign done      = (state_q == N_DONE);
	assign rgb.red   = res_q[0];
	assign rgb.green = res_q[1];
	assign rgb.blue  = res_q[2];

endmodule

### hdl/rgb_clear_normalize_serpentine.sv
// Top level of the RGBC clear-normalising serpentine scan block.
// Depends on rcns_pkg, rcns_regs, rcns_raster and rcns_norm.
//
// Usage
// One sensor reading word (clear, red, green and blue counts) enters on the
// reading channel and one pixel word leaves on the pixel channel. Each colour
// becomes floor(colour * 255 * gain / (clear * 256)), saturated at 255, with
// a Q2.8 gain per channel; a zero clear count gives black. The pixel word
// also carries the storage row and column of the point in a serpentine scan
// (column mirrored on even rows) and a flag on the last point of the scan.
//
// A single multiplier and a single compare-subtract unit serve all three
// colours in turn. Each colour takes a multiply step, a scaling step and
// one to nine division steps (one when the result saturates or clear is zero).
// The next reading is taken only once the finished word has moved to the
// pixel output register. Reading stall is high while a word is at work.
//
// The pixel output register decouples the two sides: a finished word waits
// there while the receiver stalls, and the block stays busy holding its next
// result only if a second word finishes before the first is taken. Reset
// clears the scan counters, restores the register defaults and empties the
// output. Configuration writes are taken in any cycle but belong in idle time.
module rgb_clear_normalize_serpentine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcns_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           reading_valid,
	output logic                           reading_stall,
	input  rcns_pkg::reading_t             reading,
	output logic                           pixel_valid,
	input  logic                           pixel_stall,
	output rcns_pkg::pixel_t               pixel
);
	import rcns_pkg::*;

	cfg_t   cfg;
	pos_t   pos;
	pos_t   pos_q;
	rgb_t   rgb;
	pixel_t pixel_q;
	logic   pixel_valid_q;
	logic   accept, norm_ready, norm_done, take;

	rcns_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Counters advance as the reading is accepted; its position is held in pos_q.
	rcns_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg),
		.pos     (pos)
	);

	rcns_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.reading (reading),
		.cfg     (cfg),
		.take    (take),
		.ready   (norm_ready),
		.done    (norm_done),
		.rgb     (rgb)
	);

	assign reading_stall = !norm_ready;
	assign accept        = reading_valid && norm_ready;

	// A finished word moves to the output when the register is empty or being emptied.
	assign take = norm_done && (!pixel_valid_q || !pixel_stall);

	always_ff @(posedge clk) begin
		if (accept)
			pos_q <= pos;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_q.row       <= pos_q.row;
			pixel_q.column    <= pos_q.column;
			pixel_q.scan_last <= pos_q.scan_last;
			pixel_q.red       <= rgb.red;
			pixel_q.green     <= rgb.green;
			pixel_q.blue      <= rgb.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid_q <= 1'b0;
		else if (take)
			pixel_valid_q <= 1'b1;
		else if (!pixel_stall)
			pixel_valid_q <= 1'b0;
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

endmodule

### hdl/rcns_checker.sv
// Port-level checks for the RGBC clear-normalising serpentine scan block,
// bound to the top level. Depends on rcns_pkg.
module rcns_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               reading_valid,
	input logic               reading_stall,
	input logic               pixel_valid,
	input logic               pixel_stall,
	input rcns_pkg::pixel_t   pixel
);
	import rcns_pkg::*;

	// A stalled pixel word stays put.
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
		else $error("pixel word changed or vanished while stalled");

	// Work on a word lasts at least the multiply and scaling cycles.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid && !reading_stall |=> reading_stall ##1 reading_stall)
		else $error("reading accepted again before the previous word was worked");

	// A new pixel word is only ever produced by a word that was at work.
	a_pixel_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel_valid) |-> $past(reading_stall))
		else $error("pixel word appeared without a reading at work");

endmodule

bind rgb_clear_normalize_serpentine rcns_checker u_rcns_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.reading_valid (reading_valid),
	.reading_stall (reading_stall),
	.pixel_valid   (pixel_valid),
	.pixel_stall   (pixel_stall),
	.pixel         (pixel)
);
